FILE: hw/rtl/cocktail_shaker_sort_assert.svh
// ----------------------------------------------------------------------------
// cocktail_shaker_sort_assert.svh - assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef COCKTAIL_SHAKER_SORT_ASSERT_SVH
`define COCKTAIL_SHAKER_SORT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg - shared types for the cocktail shaker sorter
// Beat structs for both channels and the sequencer state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package css_pkg;

  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } css_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_run;
    logic                      overflowed;
  } css_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BINIT,
    S_BLOAD,
    S_BCMP,
    S_BEND,
    S_FLOAD,
    S_FCMP,
    S_FEND,
    S_ORD,
    S_OUT
  } css_state_t;

endpackage

FILE: hw/rtl/css_ram.sv
// ----------------------------------------------------------------------------
// css_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module css_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/cocktail_shaker_sort.sv
// ----------------------------------------------------------------------------
// cocktail_shaker_sort - run collector and bidirectional exchange sorter
// Loads a run of signed values, sorts it ascending, streams it back out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken on any clock edge with start high and busy low.
//   Each beat carries one value; the beat with last set closes the run.
//   Busy stays low while loading, so beats may be taken back to back.
//   Beats beyond DEPTH are dropped and flag every result of that run.
//   After the last beat busy rises and the run of n held values is sorted
//   by a single compare/exchange unit stepping through the RAM, one pair
//   per cycle; each pass carries the running min (down) or max (up) in a
//   register. Sorting is paced by the one RAM read port feeding the
//   comparator. Results follow as n beats on consecutive cycles, out_valid
//   high for exactly one cycle each, smallest first; end_of_run marks the
//   last. The receiver cannot stall; busy drops in the cycle after the last
//   beat. Reset empties the run and clears the overflow flag; RAM contents
//   are left as they are, only entries of the current run are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cocktail_shaker_sort_assert.svh"

module cocktail_shaker_sort
  import css_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  css_in_t  in_data,
  output logic     out_valid,
  output css_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // control state
  css_state_t  state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;

  // sequencer payload
  logic [AW-1:0] last_idx_r, last_idx_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [VALUE_W-1:0] carry_r, carry_nxt;

  // RAM port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic          has_room;
  logic [AW-1:0] run_last;
  logic          swap;

  css_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_idx_r <= last_idx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    idx_r      <= idx_nxt;
    carry_r    <= carry_nxt;
  end

  assign has_room = (fill_r < CW'(DEPTH));
  assign run_last = has_room ? fill_r[AW-1:0] : AW'(DEPTH - 1);

  // Single shared comparator: backward pass tests RAM word > carry (carry
  // holds the running minimum), forward pass tests carry > RAM word.
  always_comb begin
    if (state_r == S_FCMP) begin
      swap = ($signed(carry_r) > $signed(ram_rdata));
    end else begin
      swap = ($signed(ram_rdata) > $signed(carry_r));
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    last_idx_nxt = last_idx_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    idx_nxt      = idx_r;
    carry_nxt    = carry_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = in_data.value;
    ram_raddr    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          // store the beat while room is left, else drop it and flag
          if (has_room) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[AW-1:0];
            fill_nxt  = fill_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            last_idx_nxt = run_last;
            lo_nxt       = '0;
            hi_nxt       = run_last;
            // a single element needs no sorting
            state_nxt    = (run_last == '0) ? S_ORD : S_BINIT;
          end
        end
      end

      S_BINIT: begin
        ram_raddr = hi_r;
        state_nxt = S_BLOAD;
      end

      S_BLOAD: begin
        carry_nxt = ram_rdata;
        idx_nxt   = hi_r;
        ram_raddr = hi_r - 1'b1;
        state_nxt = S_BCMP;
      end

      S_BCMP: begin
        // keep the smaller value moving down, write the larger at idx
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = swap ? ram_rdata : carry_r;
        carry_nxt = swap ? carry_r : ram_rdata;
        if ((idx_r - 1'b1) == lo_r) begin
          state_nxt = S_BEND;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          ram_raddr = idx_r - 1'b1 - 1'b1;
        end
      end

      S_BEND: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = carry_r;
        lo_nxt    = lo_r + 1'b1;
        if ((lo_r + 1'b1) < hi_r) begin
          ram_raddr = lo_r + 1'b1;
          state_nxt = S_FLOAD;
        end else begin
          state_nxt = S_ORD;
        end
      end

      S_FLOAD: begin
        carry_nxt = ram_rdata;
        idx_nxt   = lo_r;
        ram_raddr = lo_r + 1'b1;
        state_nxt = S_FCMP;
      end

      S_FCMP: begin
        // keep the larger value moving up, write the smaller at idx
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = swap ? ram_rdata : carry_r;
        carry_nxt = swap ? carry_r : ram_rdata;
        if ((idx_r + 1'b1) == hi_r) begin
          state_nxt = S_FEND;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1 + 1'b1;
        end
      end

      S_FEND: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = carry_r;
        hi_nxt    = hi_r - 1'b1;
        if (lo_r < (hi_r - 1'b1)) begin
          ram_raddr = hi_r - 1'b1;
          state_nxt = S_BLOAD;
        end else begin
          state_nxt = S_ORD;
        end
      end

      S_ORD: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        // stream one beat a cycle, prefetch the next address
        ram_raddr = idx_r + 1'b1;
        if (idx_r == last_idx_r) begin
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_OUT);
  assign out_data.sorted_value = ram_rdata;
  assign out_data.end_of_run   = (idx_r == last_idx_r);
  assign out_data.overflowed   = ovf_r;

  `CSS_ASSERT_IMP(a_out_while_busy, clk, rst_n, out_valid, busy,
                  "result beat outside busy window")
  `CSS_ASSERT_NXT(a_end_frees, clk, rst_n, out_valid && out_data.end_of_run, !busy,
                  "busy still high after final result beat")
  `CSS_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CW'(DEPTH),
                  "fill count beyond store depth")
  `CSS_ASSERT_IMP(a_window, clk, rst_n,
                  state_r == S_BCMP || state_r == S_FCMP || state_r == S_BEND ||
                  state_r == S_FEND || state_r == S_BLOAD || state_r == S_FLOAD,
                  lo_r < hi_r, "sort window collapsed during a pass")
  `CSS_ASSERT_IMP(a_no_write_out, clk, rst_n, out_valid, !ram_we,
                  "store written while streaming results")

endmodule
